/* design/ars_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ars_pkg: shared definitions of the array sorter
// Widths, defaults, register indexes and the sequencer state type.
// ---------------------------------------------------------------------------
package ars_pkg;

   localparam int MAX_ELEMENTS_DEF = 64;
   localparam int DATA_W           = 32;
   localparam int CSR_DATA_W       = 32;
   localparam int CSR_ADDR_W       = 3;

   // Register index, taken from paddr[2] (registers sit 4 bytes apart).
   localparam logic REG_DESCENDING = 1'b0;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_FIRST,
      ST_STEP,
      ST_END,
      ST_OUT_LD,
      ST_OUT_WAIT
   } state_type;

endpackage

/* design/ars_store.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ars_store: element memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ars_store #(
   parameter int MAX_ELEMENTS = ars_pkg::MAX_ELEMENTS_DEF,
   localparam int ADDR_W = $clog2(MAX_ELEMENTS)
) (
   input  logic                                clock,
   input  logic                                we,
   input  logic [ADDR_W-1:0]                   waddr,
   input  logic signed [ars_pkg::DATA_W-1:0]   wdata,
   input  logic [ADDR_W-1:0]                   raddr,
   output logic signed [ars_pkg::DATA_W-1:0]   rdata
);

   logic signed [ars_pkg::DATA_W-1:0] mem [MAX_ELEMENTS];
   logic signed [ars_pkg::DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/ars_csr.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ars_csr: configuration register file
// APB-style write and read access to the sort direction register.
// ---------------------------------------------------------------------------
module ars_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ars_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ars_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ars_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output logic                               descending
);

   logic descending_ff;
   logic descending_in;
   logic wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == ars_pkg::REG_DESCENDING);

   always_comb begin
      descending_in = descending_ff;
      if (wr_hit) begin
         descending_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         descending_ff <= 1'b0;
      end else begin
         descending_ff <= descending_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == ars_pkg::REG_DESCENDING) begin
         prdata[0] = descending_ff;
      end
   end

   assign descending = descending_ff;

endmodule

/* design/ars_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ars_core: load, sort and output sequencer
// Collects a set into the store, runs bubble passes through one shared
// compare unit with a carried element, then streams the store out.
// ---------------------------------------------------------------------------
module ars_core #(
   parameter int MAX_ELEMENTS = ars_pkg::MAX_ELEMENTS_DEF,
   localparam int ADDR_W = $clog2(MAX_ELEMENTS),
   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               descending,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [ars_pkg::DATA_W-1:0]  req_value,
   input  logic                               req_last_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [ars_pkg::DATA_W-1:0]  rsp_sorted_value,
   output logic                               rsp_last_out,
   output logic                               rsp_overflow,
   output logic                               mem_we,
   output logic [ADDR_W-1:0]                  mem_waddr,
   output logic signed [ars_pkg::DATA_W-1:0]  mem_wdata,
   output logic [ADDR_W-1:0]                  mem_raddr,
   input  logic signed [ars_pkg::DATA_W-1:0]  mem_rdata
);

   ars_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               dropped_ff, dropped_in;
   logic [ADDR_W-1:0]  pass_end_ff, pass_end_in;
   logic [ADDR_W-1:0]  last_idx_ff, last_idx_in;
   logic [ADDR_W-1:0]  j_ff, j_in;
   logic [ADDR_W-1:0]  k_ff, k_in;
   logic               swapped_ff, swapped_in;
   logic signed [ars_pkg::DATA_W-1:0] carry_ff, carry_in;
   logic               out_valid_ff, out_valid_in;
   logic signed [ars_pkg::DATA_W-1:0] out_value_ff, out_value_in;
   logic               out_last_ff, out_last_in;
   logic               out_ovf_ff, out_ovf_in;
   logic               swap;
   logic               has_room;

   // Shared compare unit: true when the carried element must go after the
   // element just read.
   assign swap = descending ? (carry_ff < mem_rdata) : (carry_ff > mem_rdata);
   assign has_room = (count_ff < CNT_W'(MAX_ELEMENTS));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      pass_end_in  = pass_end_ff;
      last_idx_in  = last_idx_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      swapped_in   = swapped_ff;
      carry_in     = carry_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      req_stall    = 1'b1;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = carry_ff;
      mem_raddr    = '0;

      case (state_ff)
         ars_pkg::ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (has_room) begin
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[ADDR_W-1:0];
                  mem_wdata = req_value;
                  count_in  = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last_in) begin
                  pass_end_in = has_room ? count_ff[ADDR_W-1:0]
                                         : ADDR_W'(MAX_ELEMENTS - 1);
                  last_idx_in = has_room ? count_ff[ADDR_W-1:0]
                                         : ADDR_W'(MAX_ELEMENTS - 1);
                  state_in    = ars_pkg::ST_START;
               end
            end
         end
         ars_pkg::ST_START: begin
            mem_raddr  = '0;
            swapped_in = 1'b0;
            if (pass_end_ff == '0) begin
               k_in     = '0;
               state_in = ars_pkg::ST_OUT_LD;
            end else begin
               state_in = ars_pkg::ST_FIRST;
            end
         end
         ars_pkg::ST_FIRST: begin
            carry_in  = mem_rdata;
            j_in      = ADDR_W'(1);
            mem_raddr = ADDR_W'(1);
            state_in  = ars_pkg::ST_STEP;
         end
         ars_pkg::ST_STEP: begin
            // The larger (or smaller) element keeps moving up in the carry;
            // the other one settles one slot below the read position.
            mem_we    = 1'b1;
            mem_waddr = j_ff - ADDR_W'(1);
            mem_wdata = swap ? mem_rdata : carry_ff;
            carry_in  = swap ? carry_ff : mem_rdata;
            if (swap) begin
               swapped_in = 1'b1;
            end
            if (j_ff == pass_end_ff) begin
               state_in = ars_pkg::ST_END;
            end else begin
               j_in      = j_ff + ADDR_W'(1);
               mem_raddr = j_ff + ADDR_W'(1);
            end
         end
         ars_pkg::ST_END: begin
            mem_we    = 1'b1;
            mem_waddr = pass_end_ff;
            mem_wdata = carry_ff;
            mem_raddr = '0;
            if (!swapped_ff || (pass_end_ff == ADDR_W'(1))) begin
               k_in     = '0;
               state_in = ars_pkg::ST_OUT_LD;
            end else begin
               pass_end_in = pass_end_ff - ADDR_W'(1);
               state_in    = ars_pkg::ST_START;
            end
         end
         ars_pkg::ST_OUT_LD: begin
            out_value_in = mem_rdata;
            out_last_in  = (k_ff == last_idx_ff);
            out_ovf_in   = dropped_ff;
            out_valid_in = 1'b1;
            state_in     = ars_pkg::ST_OUT_WAIT;
         end
         ars_pkg::ST_OUT_WAIT: begin
            if (!rsp_stall) begin
               out_valid_in = 1'b0;
               if (out_last_ff) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ars_pkg::ST_LOAD;
               end else begin
                  k_in      = k_ff + ADDR_W'(1);
                  mem_raddr = k_ff + ADDR_W'(1);
                  state_in  = ars_pkg::ST_OUT_LD;
               end
            end
         end
         default: begin
            state_in = ars_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ars_pkg::ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_end_ff  <= pass_end_in;
      last_idx_ff  <= last_idx_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      swapped_ff   <= swapped_in;
      carry_ff     <= carry_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sorted_value = out_value_ff;
   assign rsp_last_out     = out_last_ff;
   assign rsp_overflow     = out_ovf_ff;

endmodule

/* design/array_sorter_up_down.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// array_sorter_up_down: bubble sorter for sets of signed 32-bit words
// Collects a set, sorts it ascending or descending and streams it out.
// ---------------------------------------------------------------------------
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_stall  req_value, req_last_in
//   rsp       out        rsp_valid/rsp_stall  rsp_sorted_value, rsp_last_out,
//                                             rsp_overflow
//   csr       in/out     psel/penable/pready  paddr, pwdata, prdata
//
// An input word that does not close the set is taken without a stall. The
// closing word starts the sort: bubble passes over positions 0..e run through
// the single compare unit and the store, and passes stop early once one makes
// no swap. Each result word is then read from the store and held on rsp until
// it is taken. Input is stalled from the closing word until the final result
// word is taken. Reset clears the count and flags; the store needs no clearing
// pass.
// ---------------------------------------------------------------------------
module array_sorter_up_down #(
   parameter int MAX_ELEMENTS = ars_pkg::MAX_ELEMENTS_DEF,
   localparam int ADDR_W = $clog2(MAX_ELEMENTS)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [ars_pkg::DATA_W-1:0]  req_value,
   input  logic                               req_last_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [ars_pkg::DATA_W-1:0]  rsp_sorted_value,
   output logic                               rsp_last_out,
   output logic                               rsp_overflow,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ars_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ars_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ars_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   logic                              descending;
   logic                              mem_we;
   logic [ADDR_W-1:0]                 mem_waddr;
   logic signed [ars_pkg::DATA_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]                 mem_raddr;
   logic signed [ars_pkg::DATA_W-1:0] mem_rdata;

   ars_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .descending (descending)
   );

   ars_store #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   ars_core #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .descending       (descending),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow),
      .mem_we           (mem_we),
      .mem_waddr        (mem_waddr),
      .mem_wdata        (mem_wdata),
      .mem_raddr        (mem_raddr),
      .mem_rdata        (mem_rdata)
   );

endmodule

/* design/ars_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ars_checker: port-level assertions for the array sorter
// Checks ordering of the load and output phases as seen on the ports.
// ---------------------------------------------------------------------------
module ars_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [ars_pkg::DATA_W-1:0]  rsp_sorted_value,
   input logic                               rsp_last_out,
   input logic                               rsp_overflow
);

   // A stalled result word holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sorted_value)
         && $stable(rsp_last_out) && $stable(rsp_overflow)))
      else $error("stalled result word changed");

   // No input word is taken while results are being delivered.
   a_no_load_during_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   // The final word of a set is followed by a gap in the result stream.
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_out) |=> !rsp_valid)
      else $error("result shown right after the final word of a set");

   // An accepted input word never produces a result in the next cycle.
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("result appeared directly after an input word");

   // The overflow flag is the same for every word of one set.
   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_out) |=> ##1
         (!rsp_valid || (rsp_overflow == $past(rsp_overflow, 2))))
      else $error("overflow flag changed within a set");

endmodule

bind array_sorter_up_down ars_checker u_ars_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sorted_value (rsp_sorted_value),
   .rsp_last_out     (rsp_last_out),
   .rsp_overflow     (rsp_overflow)
);

/* sim/array_sorter_up_down_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// array_sorter_up_down_tb: self-checking bench of the array sorter
// Feeds sets of signed words, with random gaps on both sides, and checks
// every sorted word against a predictor. The sort direction is changed
// through the register port between phases, while the block is idle.
// ---------------------------------------------------------------------------
module array_sorter_up_down_tb;

   localparam int   SET_CAPACITY = ars_pkg::MAX_ELEMENTS_DEF;
   localparam int   STUCK_LIMIT  = 20000;
   localparam int   LONG_HOLD    = 400;
   localparam logic REG_UNUSED   = 1'b1;
   localparam logic signed [ars_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [ars_pkg::DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic signed [ars_pkg::DATA_W-1:0] value;
      logic                              last;
   } set_word_type;

   typedef struct packed {
      logic signed [ars_pkg::DATA_W-1:0] sorted_value;
      logic                              last_out;
      logic                              overflow;
   } sorted_word_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic signed [ars_pkg::DATA_W-1:0]     req_value = '0;
   logic                                  req_last_in = 1'b0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic signed [ars_pkg::DATA_W-1:0]     rsp_sorted_value;
   logic                                  rsp_last_out;
   logic                                  rsp_overflow;
   logic                                  psel = 1'b0;
   logic                                  penable = 1'b0;
   logic                                  pwrite = 1'b0;
   logic [ars_pkg::CSR_ADDR_W-1:0]        paddr = '0;
   logic [ars_pkg::CSR_DATA_W-1:0]        pwdata = '0;
   logic [ars_pkg::CSR_DATA_W-1:0]        prdata;
   logic                                  pready;

   set_word_type                          pending_words[$];
   sorted_word_type                       sorted_expect[$];
   logic signed [ars_pkg::DATA_W-1:0]     set_store[0:SET_CAPACITY-1];
   int                                    set_count = 0;
   logic                                  set_dropped = 1'b0;
   logic                                  sort_descending = 1'b0;
   int                                    mismatch_count = 0;
   int                                    results_seen = 0;
   logic                                  idle_on = 1'b1;
   int                                    send_gap = 0;
   int                                    stall_left = 0;
   logic                                  long_hold_done = 1'b0;
   int                                    stuck_cycles = 0;

   array_sorter_up_down dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_value(req_value), .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sorted_value(rsp_sorted_value), .rsp_last_out(rsp_last_out),
      .rsp_overflow(rsp_overflow),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stores one accepted word and, on the closing word, queues the sorted set.
   task automatic predict_word(input logic signed [ars_pkg::DATA_W-1:0] value,
                               input logic last);
      logic signed [ars_pkg::DATA_W-1:0] key;
      sorted_word_type                   word;
      int                                i;
      int                                j;
      if (set_count < SET_CAPACITY) begin
         set_store[set_count] = value;
         set_count++;
      end else begin
         set_dropped = 1'b1;
      end
      if (last) begin
         for (i = 1; i < set_count; i++) begin
            key = set_store[i];
            j = i - 1;
            while (j >= 0 && (sort_descending ? set_store[j] < key : set_store[j] > key)) begin
               set_store[j + 1] = set_store[j];
               j--;
            end
            set_store[j + 1] = key;
         end
         for (i = 0; i < set_count; i++) begin
            word.sorted_value = set_store[i];
            word.last_out     = (i == set_count - 1);
            word.overflow     = set_dropped;
            sorted_expect.push_back(word);
         end
         set_count   = 0;
         set_dropped = 1'b0;
      end
   endtask

   // Driver: a new word is offered only once the current one has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_valid   <= 1'b1;
            req_value   <= pending_words[0].value;
            req_last_in <= pending_words[0].last;
            void'(pending_words.pop_front());
            if (idle_on && $urandom_range(0, 7) == 0)
               send_gap <= $urandom_range(1, 14);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold once results flow.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (!long_hold_done && results_seen >= 60 && rsp_valid) begin
         long_hold_done <= 1'b1;
         stall_left     <= LONG_HOLD;
         rsp_stall      <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left != 1);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 14);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: tracks the direction register, predicts and checks.
   always @(posedge clock) begin
      sorted_word_type want;
      if (!reset) begin
         if (psel && penable && pwrite && pready && paddr[2] == ars_pkg::REG_DESCENDING)
            sort_descending = pwdata[0];
         if (req_valid && !req_stall)
            predict_word(req_value, req_last_in);
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (sorted_expect.size() == 0) begin
               $error("Unexpected result word: sorted_value %0d", rsp_sorted_value);
               mismatch_count++;
            end else begin
               want = sorted_expect.pop_front();
               if (rsp_sorted_value !== want.sorted_value) begin
                  $error("sorted_value: expected %0d, got %0d",
                         want.sorted_value, rsp_sorted_value);
                  mismatch_count++;
               end
               if (rsp_last_out !== want.last_out) begin
                  $error("last_out: expected %0d, got %0d", want.last_out, rsp_last_out);
                  mismatch_count++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow: expected %0d, got %0d", want.overflow, rsp_overflow);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic queue_word(input logic signed [ars_pkg::DATA_W-1:0] value,
                             input logic last);
      set_word_type word;
      word.value = value;
      word.last  = last;
      pending_words.push_back(word);
   endtask

   // Random content: extremes and a narrow band for duplicates now and then.
   task automatic queue_set(input int size);
      logic signed [ars_pkg::DATA_W-1:0] value;
      int                                k;
      for (k = 0; k < size; k++) begin
         case ($urandom_range(0, 9))
            0:       value = WORD_MIN;
            1:       value = WORD_MAX;
            2, 3:    value = $signed($urandom_range(0, 6)) - 3;
            default: value = $urandom;
         endcase
         queue_word(value, k == size - 1);
      end
   endtask

   task automatic csr_write(input logic reg_index,
                            input logic [ars_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // The block stalls input until its last result word is taken, so a short
   // pause after the final result is enough before touching the register.
   task automatic wait_idle();
      while (pending_words.size() != 0 || req_valid || sorted_expect.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   initial begin
      int phase;
      int queued;
      int size;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Ascending after reset: single word, extremes, duplicates.
      queue_word(32'sd0, 1'b1);
      queue_word(WORD_MAX, 1'b0);
      queue_word(WORD_MIN, 1'b0);
      queue_word(-32'sd1, 1'b0);
      queue_word(32'sd1, 1'b0);
      queue_word(32'sd0, 1'b1);
      queue_word(32'sd5, 1'b0);
      queue_word(-32'sd5, 1'b0);
      queue_word(32'sd5, 1'b0);
      queue_word(32'sd5, 1'b1);
      wait_idle();

      // Descending, with junk in the unused upper bits of the write.
      csr_write(ars_pkg::REG_DESCENDING, 32'hffff_fffe | 32'h1);
      queue_word(WORD_MIN, 1'b0);
      queue_word(WORD_MAX, 1'b0);
      queue_word(32'sd1, 1'b0);
      queue_word(-32'sd1, 1'b0);
      queue_word(32'sd0, 1'b1);
      queue_word(WORD_MIN, 1'b1);
      wait_idle();

      // A write to an unused register index must leave the direction alone.
      csr_write(REG_UNUSED, 32'h0000_0000);
      queue_word(32'sd3, 1'b0);
      queue_word(32'sd7, 1'b0);
      queue_word(-32'sd2, 1'b1);
      wait_idle();

      for (phase = 0; phase < 4; phase++) begin
         csr_write(ars_pkg::REG_DESCENDING, ($urandom & 32'hffff_fffe) | phase[0]);
         if (phase == 3)
            idle_on = 1'b0;
         if (phase == 0) begin
            // Exactly full, then overflowing with the closing word dropped.
            queue_set(SET_CAPACITY);
            queue_set(SET_CAPACITY + 3);
         end
         queued = 0;
         while (queued < 35) begin
            if ($urandom_range(0, 24) == 0)
               size = $urandom_range(SET_CAPACITY - 4, SET_CAPACITY + 6);
            else
               size = $urandom_range(1, 12);
            queue_set(size);
            queued += size;
         end
         wait_idle();
      end

      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* sim.f */
design/ars_pkg.sv
design/ars_store.sv
design/ars_csr.sv
design/ars_core.sv
design/array_sorter_up_down.sv
design/ars_checker.sv
sim/array_sorter_up_down_tb.sv
